@@ src/tsce_pkg.sv @@
// tsce_pkg: shared types, codes and the microcode program for the taylor series core
// used by tsce_seq, tsce_dpath and the top level; no dependencies

package tsce_pkg;

    // datapath operation selected by a control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_ADD,
        OP_MLOAD,
        OP_MCLR,
        OP_MUL,
        OP_MFIN,
        OP_DSET,
        OP_DIV,
        OP_TUPD,
        OP_EMIT
    } op_t;

    // jump condition of a control word
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_STOP,
        C_LOOP,
        C_EXP,
        C_OUT_BUSY
    } cond_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] upc_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
        logic  inc_n;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic start;
        logic stop;
        logic loop_on;
        logic is_exp;
        logic out_busy;
    } status_t;

    // function select codes
    localparam logic [1:0] ACT_SIN = 2'd0;
    localparam logic [1:0] ACT_COS = 2'd1;
    localparam logic [1:0] ACT_EXP = 2'd2;

    // program entry points
    localparam upc_t A_IDLE = 4'd0;
    localparam upc_t A_TEST = 4'd2;
    localparam upc_t A_MUL1 = 4'd4;
    localparam upc_t A_MUL2 = 4'd7;
    localparam upc_t A_DSET = 4'd9;
    localparam upc_t A_DIV  = 4'd10;
    localparam upc_t A_DONE = 4'd13;

    // microcode program, one control word per step
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE, inc_n: 1'b0};
        unique case (addr)
            4'd0:  w = '{op: OP_IDLE,  cond: C_NO_START, target: A_IDLE, inc_n: 1'b0};
            4'd1:  w = '{op: OP_ADD,   cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd2:  w = '{op: OP_NOP,   cond: C_STOP,     target: A_DONE, inc_n: 1'b0};
            4'd3:  w = '{op: OP_MLOAD, cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd4:  w = '{op: OP_MUL,   cond: C_LOOP,     target: A_MUL1, inc_n: 1'b0};
            4'd5:  w = '{op: OP_MFIN,  cond: C_EXP,      target: A_DSET, inc_n: 1'b0};
            4'd6:  w = '{op: OP_MCLR,  cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd7:  w = '{op: OP_MUL,   cond: C_LOOP,     target: A_MUL2, inc_n: 1'b0};
            4'd8:  w = '{op: OP_MFIN,  cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd9:  w = '{op: OP_DSET,  cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd10: w = '{op: OP_DIV,   cond: C_LOOP,     target: A_DIV,  inc_n: 1'b0};
            4'd11: w = '{op: OP_TUPD,  cond: C_NEVER,    target: A_IDLE, inc_n: 1'b0};
            4'd12: w = '{op: OP_ADD,   cond: C_ALWAYS,   target: A_TEST, inc_n: 1'b1};
            4'd13: w = '{op: OP_NOP,   cond: C_OUT_BUSY, target: A_DONE, inc_n: 1'b0};
            4'd14: w = '{op: OP_EMIT,  cond: C_ALWAYS,   target: A_IDLE, inc_n: 1'b0};
            default: w = '{op: OP_NOP, cond: C_ALWAYS,   target: A_IDLE, inc_n: 1'b0};
        endcase
        return w;
    endfunction

endpackage

@@ src/tsce_seq.sv @@
// tsce_seq: microcode sequencer, step counter plus conditional jump
// depends on tsce_pkg (control word, status flags, program table)

module tsce_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  tsce_pkg::status_t status,
    output tsce_pkg::ucode_t  cw
);
    import tsce_pkg::*;

    upc_t pc_reg;
    upc_t pc_next;
    logic take;

    assign cw = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !status.start;
            C_STOP:     take = status.stop;
            C_LOOP:     take = status.loop_on;
            C_EXP:      take = status.is_exp;
            C_OUT_BUSY: take = status.out_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? cw.target : upc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/tsce_dpath.sv @@
// tsce_dpath: term, sum, 32x32 multiplier (four partial products per 64x64 multiply) and bit-serial divider datapath
// depends on tsce_pkg; driven by the control word from tsce_seq

module tsce_dpath #(
    parameter int TERM_LIMIT = 1000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tsce_pkg::ucode_t    cw,
    input  logic                in_valid,
    input  logic [1:0]          action,
    input  logic signed [63:0]  x_value,
    input  logic [39:0]         tolerance,
    input  logic [9:0]          max_terms,
    input  logic                out_ready,
    output tsce_pkg::status_t   status,
    output logic                out_valid,
    output logic signed [63:0]  approx,
    output logic [9:0]          term_count,
    output logic                overflow
);
    import tsce_pkg::*;

    localparam int NW = $clog2(TERM_LIMIT + 1);
    localparam int LW = (NW > 10) ? NW : 10;
    localparam int DW = 2 * NW + 2;
    localparam logic [5:0] MUL_LAST = 6'd4;
    localparam logic [5:0] DIV_LAST = 6'd63;
    localparam logic [63:0] ONE_Q40 = 64'h0000_0100_0000_0000;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // saturating add of a sign-magnitude term; returns {overflow, sum}
    function automatic logic [64:0] sat_add(input logic signed [63:0] s,
                                            input logic neg,
                                            input logic [63:0] mag);
        logic signed [64:0] v;
        logic signed [64:0] t;
        logic [63:0] r;
        logic o;
        if (neg)
            v = mag[63] ? {2'b11, 63'b0} : -$signed({1'b0, mag});
        else
            v = mag[63] ? {2'b00, {63{1'b1}}} : $signed({1'b0, mag});
        t = {s[63], s} + v;
        o = (t[64] != t[63]);
        if (o)
            r = t[64] ? {1'b1, 63'b0} : MAG_MAX;
        else
            r = t[63:0];
        return {o, r};
    endfunction

    logic [1:0]         act_reg, act_next;
    logic               xneg_reg, xneg_next;
    logic [63:0]        xmag_reg, xmag_next;
    logic [39:0]        tol_reg, tol_next;
    logic [NW-1:0]      lim_reg, lim_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               tneg_reg, tneg_next;
    logic [63:0]        tmag_reg, tmag_next;
    logic signed [63:0] sum_reg, sum_next;
    logic               ovf_reg, ovf_next;
    logic [127:0]       acc_reg, acc_next;
    logic [63:0]        pp_reg, pp_next;
    logic [1:0]         psh_reg, psh_next;
    logic [63:0]        mop_reg, mop_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [DW-1:0]      dvs_reg, dvs_next;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic signed [63:0] approx_reg, approx_next;
    logic [9:0]         terms_reg, terms_next;
    logic               ovfo_reg, ovfo_next;
    logic               out_valid_reg, out_valid_next;

    logic               is_exp;
    logic [63:0]        x_u;
    logic [LW-1:0]      mt_ext;
    logic [LW-1:0]      lim_w;
    logic [LW-1:0]      n_ext;
    logic [1:0]         k;
    logic [31:0]        ah;
    logic [31:0]        bh;
    logic [63:0]        pp_prod;
    logic [NW:0]        fa;
    logic [NW:0]        fb;
    logic [DW-1:0]      dprod;
    logic [DW:0]        rs;
    logic [64:0]        add_res;

    assign is_exp  = (act_reg == ACT_EXP);
    assign x_u     = x_value;
    assign mt_ext  = LW'(max_terms);
    assign lim_w   = (mt_ext == '0) ? LW'(1)
                   : ((mt_ext > LW'(TERM_LIMIT)) ? LW'(TERM_LIMIT) : mt_ext);
    assign n_ext   = LW'(n_reg);
    assign k       = cnt_reg[1:0];
    assign ah      = k[0] ? mop_reg[63:32] : mop_reg[31:0];
    assign bh      = k[1] ? xmag_reg[63:32] : xmag_reg[31:0];
    assign pp_prod = 64'(ah) * 64'(bh);
    assign fa      = (act_reg == ACT_SIN) ? {n_reg, 1'b0} : ({n_reg, 1'b0} - 1'b1);
    assign fb      = fa + 1'b1;
    assign dprod   = DW'(fa) * DW'(fb);
    assign rs      = {rem_reg, quo_reg[63]};
    assign add_res = sat_add(sum_reg, tneg_reg, tmag_reg);

    always_comb
    begin
        status.start    = in_valid;
        status.stop     = !((tmag_reg > {24'b0, tol_reg}) && (n_reg < lim_reg));
        status.loop_on  = (cw.op == OP_MUL) ? (cnt_reg != MUL_LAST) : (cnt_reg != DIV_LAST);
        status.is_exp   = is_exp;
        status.out_busy = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        act_next    = act_reg;
        xneg_next   = xneg_reg;
        xmag_next   = xmag_reg;
        tol_next    = tol_reg;
        lim_next    = lim_reg;
        n_next      = n_reg;
        tneg_next   = tneg_reg;
        tmag_next   = tmag_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        psh_next    = psh_reg;
        mop_next    = mop_reg;
        cnt_next    = cnt_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        approx_next = approx_reg;
        terms_next  = terms_reg;
        ovfo_next   = ovfo_reg;
        unique case (cw.op)
            OP_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = (action == ACT_SIN || action == ACT_COS) ? action : ACT_EXP;
                    xneg_next = x_u[63];
                    xmag_next = x_u[63] ? (~x_u + 64'd1) : x_u;
                    tol_next  = tolerance;
                    lim_next  = NW'(lim_w);
                    n_next    = NW'(1);
                    sum_next  = '0;
                    ovf_next  = 1'b0;
                    if (action == ACT_SIN)
                    begin
                        tneg_next = x_u[63];
                        tmag_next = x_u[63] ? (~x_u + 64'd1) : x_u;
                    end
                    else
                    begin
                        tneg_next = 1'b0;
                        tmag_next = ONE_Q40;
                    end
                end
            end
            OP_ADD:
            begin
                sum_next = add_res[63:0];
                ovf_next = ovf_reg | add_res[64];
                if (cw.inc_n)
                    n_next = n_reg + 1'b1;
            end
            OP_MLOAD:
            begin
                mop_next = tmag_reg;
                acc_next = '0;
                cnt_next = '0;
            end
            OP_MCLR:
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            OP_MUL:
            begin
                // partial product issued into pp_reg, accumulated in the next cycle
                if (cnt_reg != MUL_LAST)
                begin
                    pp_next  = pp_prod;
                    psh_next = {1'b0, k[0]} + {1'b0, k[1]};
                end
                if (cnt_reg != '0)
                    acc_next = acc_reg + ({64'b0, pp_reg} << {psh_reg, 5'b0});
                cnt_next = cnt_reg + 1'b1;
            end
            OP_MFIN:
            begin
                if (acc_reg[127:103] != '0)
                begin
                    mop_next = MAG_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    mop_next = {1'b0, acc_reg[102:40]};
                end
            end
            OP_DSET:
            begin
                dvs_next = is_exp ? DW'(n_reg) : dprod;
                rem_next = '0;
                quo_next = mop_reg;
                cnt_next = '0;
            end
            OP_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rs >= {1'b0, dvs_reg})
                begin
                    rem_next = DW'(rs - {1'b0, dvs_reg});
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rs[DW-1:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_TUPD:
            begin
                tmag_next = quo_reg;
                tneg_next = is_exp ? (tneg_reg ^ xneg_reg) : !tneg_reg;
            end
            OP_EMIT:
            begin
                approx_next = sum_reg;
                terms_next  = n_ext[9:0];
                ovfo_next   = ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cw.op == OP_EMIT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        xneg_reg   <= xneg_next;
        xmag_reg   <= xmag_next;
        tol_reg    <= tol_next;
        lim_reg    <= lim_next;
        n_reg      <= n_next;
        tneg_reg   <= tneg_next;
        tmag_reg   <= tmag_next;
        sum_reg    <= sum_next;
        ovf_reg    <= ovf_next;
        acc_reg    <= acc_next;
        pp_reg     <= pp_next;
        psh_reg    <= psh_next;
        mop_reg    <= mop_next;
        cnt_reg    <= cnt_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        approx_reg <= approx_next;
        terms_reg  <= terms_next;
        ovfo_reg   <= ovfo_next;
    end

    assign out_valid  = out_valid_reg;
    assign approx     = approx_reg;
    assign term_count = terms_reg;
    assign overflow   = ovfo_reg;

endmodule

@@ src/taylor_series_sin_cos_exp_core.sv @@
// taylor_series_sin_cos_exp_core: top level of the taylor series sin/cos/exp evaluator
// depends on tsce_pkg, tsce_seq and tsce_dpath

// Evaluates sin, cos or exp of a signed Q24.40 point by summing its Taylor
// series term by term until the term magnitude drops to the tolerance or the
// term count reaches max_terms (0 acts as 1, values above TERM_LIMIT act as
// TERM_LIMIT). Terms are kept as sign and magnitude; every product is
// truncated toward zero and clamped to 2^63-1, every quotient truncates, and
// the running sum saturates; any clamp raises overflow. One item is in work at
// a time. The per-term cost is set by the bit-serial restoring divider and by
// the 64x64 multiply, done as four 32x32 partial products on one multiplier
// (twice per term for sin and cos). The result sits in an output register, so
// the next input transfer is taken as soon as the result is loaded there, even
// while it still waits for out_ready.

module taylor_series_sin_cos_exp_core #(
    parameter int TERM_LIMIT = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [63:0] x_value,
    input  logic [39:0]        tolerance,
    input  logic [9:0]         max_terms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] approx,
    output logic [9:0]         term_count,
    output logic               overflow
);
    import tsce_pkg::*;

    // control word of the current microcode step
    ucode_t  cw;
    // condition flags fed back for the jumps
    status_t status;

    // the idle step is the only one that takes an input transfer
    assign in_ready = (cw.op == OP_IDLE);

    tsce_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    tsce_dpath #(
        .TERM_LIMIT (TERM_LIMIT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cw         (cw),
        .in_valid   (in_valid),
        .action     (action),
        .x_value    (x_value),
        .tolerance  (tolerance),
        .max_terms  (max_terms),
        .out_ready  (out_ready),
        .status     (status),
        .out_valid  (out_valid),
        .approx     (approx),
        .term_count (term_count),
        .overflow   (overflow)
    );

endmodule

@@ src/tsce_check.sv @@
// tsce_check: port-level assertions for the taylor series core, with its bind
// depends only on the ports of taylor_series_sin_cos_exp_core

module tsce_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [63:0] approx,
    input logic [9:0]         term_count
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(approx) && $stable(term_count))
        else $error("output result changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while busy");

    // a new result appears only out of the busy phase
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // at least one term is always summed
    a_terms_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> term_count != 10'd0)
        else $error("zero terms reported");

endmodule

bind taylor_series_sin_cos_exp_core tsce_check u_check (.*);
